// ===== rtl/gray_cell_halftone_2x2_defines.svh =====
// assertion macros for the 2x2 cell halftone block
// used by the port checker only, no other dependencies
`ifndef GRAY_CELL_HALFTONE_2X2_DEFINES_SVH
`define GRAY_CELL_HALFTONE_2X2_DEFINES_SVH

// same-cycle implication, quiet during reset
`define GCH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gch check failed");

// next-cycle implication, quiet during reset
`define GCH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gch check failed");

`endif

// ===== rtl/gch_pkg.sv =====
// shared types and constants of the 2x2 cell halftone block
// no dependencies
package gch_pkg;

  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 11;
  localparam int GRAY_W    = 8;
  localparam int SUM_W     = 10;
  localparam int CFG_W     = 13;

  // register indexes of the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int HEIGHT_CAP = 4096;

  // cell thresholds for the four positions
  localparam logic [SUM_W-1:0] THR_A = SUM_W'((1 * 1024) / 8);
  localparam logic [SUM_W-1:0] THR_B = SUM_W'((3 * 1024) / 8);
  localparam logic [SUM_W-1:0] THR_C = SUM_W'((5 * 1024) / 8);
  localparam logic [SUM_W-1:0] THR_D = SUM_W'((7 * 1024) / 8);

  // divide by three: (s * 683) >> 11 is exact for s up to 765
  localparam logic [20:0] GRAY_RECIP = 21'd683;
  localparam int          GRAY_SHIFT = 11;

  // result slots of a cell, in emission order
  localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;
  localparam logic [1:0] SLOT_HERE     = 2'd1;
  localparam logic [1:0] SLOT_LEFT     = 2'd2;
  localparam logic [1:0] SLOT_UP_RIGHT = 2'd3;

  typedef struct packed {
    logic                 is_cell;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_ROW_W-1:0] row_up;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_COL_W-1:0] col_left;
    logic [GRAY_W-1:0]    gray;
    logic [3:0]           lev;
  } gch_job_t;

endpackage

// ===== rtl/gray_cell_halftone_2x2.sv =====
// top level of the 2x2 cell halftone block
// depends on gch_pkg, gch_line_buf and gch_emit
//
// Pixels enter in raster order on in_valid/in_ready/pixel_word; results leave
// on out_valid/out_ready with out_row, out_col, out_pixel and last_of_run.
// Each pixel becomes gray = (b0 + b1 + b2) / 3. Even-row grays go to a line
// buffer and give no result. On an odd row an even column is held, and the
// following odd column completes a 2x2 cell that yields four requests, the
// last flagged by last_of_run. Leftover edge pixels pass through as gray.
// The first result passes the stage after the line buffer read and the job
// register in the sequencer before it is offered.
// Throughput: one pixel per cycle on even rows and at pass-through edges
// while the receiver keeps up; on odd rows the single output port sets the
// pace, four requests per two pixels.
// The input stays ready while earlier results wait: a one-item stage after
// the line buffer read and a job register in the sequencer decouple the two
// sides. A stalled receiver backs up into these stages, then the input.
// Reset clears the counters, width 640 and height 480; the line buffer is
// not cleared and needs no pass. Configuration writes take effect at once; the
// user makes them only while the block is idle, the block does not enforce it.
module gray_cell_halftone_2x2
  import gch_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          pixel_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic [23:0]          out_pixel,
  output logic                 last_of_run
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic [COL_W-1:0]     W_LAST_RESET = COL_W'(W_RESET - 1);
  localparam logic [OUT_ROW_W-1:0] H_LAST_RESET = OUT_ROW_W'(480 - 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PASS,
    KIND_LEFT,
    KIND_CELL
  } kind_t;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [31:0] p);
    logic [SUM_W-1:0] s;
    logic [20:0]      prod;
    s    = SUM_W'(p[7:0]) + SUM_W'(p[15:8]) + SUM_W'(p[23:16]);
    prod = 21'(s) * GRAY_RECIP;
    return prod[GRAY_SHIFT+GRAY_W-1:GRAY_SHIFT];
  endfunction

  // effective last column and last row, kept already clamped
  logic [COL_W-1:0]     w_last;
  logic [OUT_ROW_W-1:0] h_last;
  logic [COL_W-1:0]     w_last_next;
  logic [OUT_ROW_W-1:0] h_last_next;

  logic [OUT_ROW_W-1:0] row_cnt;
  logic [COL_W-1:0]     col_cnt;

  logic              accept;
  logic              last_col;
  logic              last_row;
  kind_t             in_kind;
  logic [GRAY_W-1:0] in_gray;

  // stage after the line buffer read
  logic                 a_valid;
  kind_t                a_kind;
  logic [OUT_ROW_W-1:0] a_row;
  logic [COL_W-1:0]     a_col;
  logic [GRAY_W-1:0]    a_gray;
  logic                 a_take;

  logic [GRAY_W-1:0] left_gray;
  logic [GRAY_W-1:0] up_left;
  logic [GRAY_W-1:0] buf_q;
  logic              buf_we;
  logic              buf_re;

  logic [SUM_W-1:0] cell_sum;
  gch_job_t         job;
  logic             job_valid;
  logic             job_ready;

  always_comb begin
    if (cfg_data[11:0] == 12'd0) begin
      w_last_next = '0;
    end else if (32'(cfg_data[11:0]) > 32'(MAX_WIDTH)) begin
      w_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last_next = COL_W'(cfg_data[11:0] - 12'd1);
    end
    if (cfg_data == '0) begin
      h_last_next = '0;
    end else if (32'(cfg_data) > 32'(HEIGHT_CAP)) begin
      h_last_next = OUT_ROW_W'(HEIGHT_CAP - 1);
    end else begin
      h_last_next = OUT_ROW_W'(cfg_data - 13'd1);
    end
  end

  assign in_gray  = gray_of(pixel_word);
  assign last_col = col_cnt >= w_last;
  assign last_row = row_cnt >= h_last;

  always_comb begin
    if (!row_cnt[0]) begin
      in_kind = (last_row || (last_col && !col_cnt[0])) ? KIND_PASS : KIND_NONE;
    end else if (!col_cnt[0]) begin
      in_kind = last_col ? KIND_PASS : KIND_LEFT;
    end else begin
      in_kind = KIND_CELL;
    end
  end

  // the held left pixel never waits, so it always leaves its stage
  assign a_take   = a_valid && ((a_kind == KIND_LEFT) || job_ready);
  assign in_ready = !a_valid || a_take;
  assign accept   = in_valid && in_ready;

  // writes come from even rows and reads from odd rows, one a cycle at the
  // accept edge, so a read never meets a write to the same entry
  assign buf_we = accept && !row_cnt[0] && (in_kind == KIND_NONE);
  assign buf_re = accept && row_cnt[0];

  gch_line_buf #(
    .DEPTH(MAX_WIDTH),
    .AW   (COL_W)
  ) u_line_buf (
    .clk  (clk),
    .we   (buf_we),
    .waddr(col_cnt),
    .wdata(in_gray),
    .re   (buf_re),
    .raddr(col_cnt),
    .rdata(buf_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last    <= W_LAST_RESET;
      h_last    <= H_LAST_RESET;
      row_cnt   <= '0;
      col_cnt   <= '0;
      a_valid   <= 1'b0;
      left_gray <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  w_last <= w_last_next;
          REG_IMAGE_HEIGHT: h_last <= h_last_next;
          default: ;
        endcase
      end
      if (accept) begin
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : row_cnt + 1'b1;
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
      if (accept) begin
        a_valid <= (in_kind != KIND_NONE);
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
      if (a_valid && (a_kind == KIND_LEFT)) begin
        left_gray <= a_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind <= in_kind;
      a_row  <= row_cnt;
      a_col  <= col_cnt;
      a_gray <= in_gray;
    end
    if (a_valid && (a_kind == KIND_LEFT)) begin
      up_left <= buf_q;
    end
  end

  assign cell_sum = SUM_W'(up_left) + SUM_W'(buf_q) + SUM_W'(left_gray) + SUM_W'(a_gray);

  always_comb begin
    job.is_cell  = (a_kind == KIND_CELL);
    job.row      = a_row;
    job.row_up   = a_row - 1'b1;
    job.col      = OUT_COL_W'(a_col);
    job.col_left = OUT_COL_W'(a_col - 1'b1);
    job.gray     = a_gray;
    job.lev[0]   = cell_sum > THR_A;
    job.lev[1]   = cell_sum > THR_B;
    job.lev[2]   = cell_sum > THR_C;
    job.lev[3]   = cell_sum > THR_D;
  end

  assign job_valid = a_valid && ((a_kind == KIND_PASS) || (a_kind == KIND_CELL));

  gch_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (job_valid),
    .load_ready (job_ready),
    .load_job   (job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_pixel  (out_pixel),
    .last_of_run(last_of_run)
  );

endmodule

// ===== rtl/gch_line_buf.sv =====
// line buffer holding the gray values of the last even row
// one write and one registered read port, no dependencies
module gch_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gch_emit.sv =====
// result sequencer: turns one job into one or four output requests
// depends on gch_pkg
module gch_emit
  import gch_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  gch_job_t             load_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic [23:0]          out_pixel,
  output logic                 last_of_run
);

  logic     job_valid;
  gch_job_t job;
  logic [1:0] slot;

  assign last_of_run = !job.is_cell || (slot == SLOT_UP_RIGHT);
  assign out_valid   = job_valid;
  assign load_ready  = !job_valid || (out_ready && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      slot      <= SLOT_UP_LEFT;
    end else begin
      if (load_ready) begin
        job_valid <= load_valid;
      end
      if (load_ready && load_valid) begin
        slot <= SLOT_UP_LEFT;
      end else if (job_valid && out_ready) begin
        slot <= slot + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      job <= load_job;
    end
  end

  always_comb begin
    out_row   = job.row;
    out_col   = job.col;
    out_pixel = {3{job.gray}};
    if (job.is_cell) begin
      out_pixel = {24{job.lev[slot]}};
      case (slot)
        SLOT_UP_LEFT: begin
          out_row = job.row_up;
          out_col = job.col_left;
        end
        SLOT_HERE: begin
          out_row = job.row;
          out_col = job.col;
        end
        SLOT_LEFT: begin
          out_row = job.row;
          out_col = job.col_left;
        end
        SLOT_UP_RIGHT: begin
          out_row = job.row_up;
          out_col = job.col;
        end
        default: begin
          out_row = job.row;
          out_col = job.col;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gch_checker.sv =====
// port-level checks of the 2x2 cell halftone block, bound to the top level
// depends on gch_pkg and gray_cell_halftone_2x2_defines.svh
`include "gray_cell_halftone_2x2_defines.svh"

module gch_checker
  import gch_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_pixel,
  input logic        last_of_run
);

  logic bytes_same;

  assign bytes_same = (out_pixel[7:0] == out_pixel[15:8]) &&
                      (out_pixel[15:8] == out_pixel[23:16]);

  // a stalled request is still offered next cycle
  `GCH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // the three colour bytes always carry the same value
  `GCH_ASSERT_NOW(a_grey_bytes, clk, rst, out_valid, bytes_same)

  // the requests of one cell follow each other without a gap
  `GCH_ASSERT_NEXT(a_cell_run, clk, rst, out_valid && out_ready && !last_of_run, out_valid)

  // coming out of reset the block is empty and takes pixels
  `GCH_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), in_ready && !out_valid)

endmodule

bind gray_cell_halftone_2x2 gch_checker u_gch_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_pixel  (out_pixel),
  .last_of_run(last_of_run)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the 2x2 cell halftone block gray_cell_halftone_2x2
// drives pixel requests and register writes, predicts every output pixel in step
// depends on gch_pkg and the block's rtl only
module testbench;
  import gch_pkg::*;

  localparam int          LINE_MAX      = 2048;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned CUT_UP_LEFT   = (1 * 1024) / 8;
  localparam int unsigned CUT_HERE      = (3 * 1024) / 8;
  localparam int unsigned CUT_LEFT      = (5 * 1024) / 8;
  localparam int unsigned CUT_UP_RIGHT  = (7 * 1024) / 8;
  localparam int unsigned RANDOM_PIXELS = 250;
  localparam int unsigned PAD_CAP       = 100;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [23:0]          pixel;
    logic                 last;
  } halftone_result_t;

  typedef struct {
    logic [31:0] pixel;
    bit          drain_first;
  } pixel_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          pixel_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic [23:0]          out_pixel;
  logic                 last_of_run;

  // predictor state
  logic [11:0]          geom_width = 12'd640;
  logic [12:0]          geom_height = 13'd480;
  logic [7:0]           line_gray [LINE_MAX];
  logic [7:0]           held_gray = 8'h00;
  logic [OUT_ROW_W-1:0] cur_row = '0;
  logic [OUT_COL_W-1:0] cur_col = '0;

  pixel_req_t       pending_pixels [$];
  halftone_result_t halftone_due [$];

  int pixels_sent = 0;
  int pixels_taken = 0;
  int results_taken = 0;
  int stall_mark = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  gray_cell_halftone_2x2 #(.MAX_WIDTH(LINE_MAX)) u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .pixel_word,
    .out_valid, .out_ready, .out_row, .out_col, .out_pixel, .last_of_run
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_width(logic [11:0] w);
    if (w == 0) return 1;
    if (w > LINE_MAX) return LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height(logic [12:0] h);
    if (h == 0) return 1;
    if (h > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic void step_position(inout logic [OUT_ROW_W-1:0] row,
                                        inout logic [OUT_COL_W-1:0] col,
                                        input int unsigned w, input int unsigned h);
    if (int'(col) + 1 >= w) begin
      col = '0;
      row = (int'(row) + 1 >= h) ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endfunction

  function automatic logic [7:0] cell_level(int unsigned sum, int unsigned cut);
    return (sum > cut) ? 8'hFF : 8'h00;
  endfunction

  function automatic void push_result(int unsigned r, int unsigned c, logic [7:0] v,
                                      logic last);
    halftone_result_t res;
    res.row   = r[OUT_ROW_W-1:0];
    res.col   = c[OUT_COL_W-1:0];
    res.pixel = {3{v}};
    res.last  = last;
    halftone_due.push_back(res);
  endfunction

  // expected output pixels for one taken pixel request
  function automatic void halftone_pixel(logic [31:0] px);
    int unsigned w, h, g, sum, r, c;
    logic row_odd, col_odd, col_end, row_end;
    w = eff_width(geom_width);
    h = eff_height(geom_height);
    g = (int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16])) / 3;
    r = cur_row;
    c = cur_col;
    row_odd = r[0];
    col_odd = c[0];
    col_end = (c + 1 >= w);
    row_end = (r + 1 >= h);
    if (!row_odd) begin
      if (row_end || (col_end && !col_odd)) push_result(r, c, g[7:0], 1'b1);
      else line_gray[c] = g[7:0];
    end else if (!col_odd) begin
      if (col_end) push_result(r, c, g[7:0], 1'b1);
      else held_gray = g[7:0];
    end else begin
      sum = line_gray[c-1] + line_gray[c] + held_gray + g;
      push_result(r - 1, c - 1, cell_level(sum, CUT_UP_LEFT), 1'b0);
      push_result(r, c, cell_level(sum, CUT_HERE), 1'b0);
      push_result(r, c - 1, cell_level(sum, CUT_LEFT), 1'b0);
      push_result(r - 1, c, cell_level(sum, CUT_UP_RIGHT), 1'b1);
    end
    step_position(cur_row, cur_col, w, h);
  endfunction

  // pixels needed to reach column zero of an even row under the current geometry
  function automatic int unsigned pixels_to_even_row();
    logic [OUT_ROW_W-1:0] r;
    logic [OUT_COL_W-1:0] c;
    int unsigned n;
    r = cur_row;
    c = cur_col;
    n = 0;
    while (!(c == 0 && !r[0]) && n <= PAD_CAP) begin
      step_position(r, c, eff_width(geom_width), eff_height(geom_height));
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] make_pixel();
    logic [7:0]  g;
    logic [31:0] px;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: px = $urandom();
      4, 5, 6: begin
        // grays around the cell cuts so that sums land on either side
        g  = 8'(32 + 64 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
        px = {8'($urandom()), g, g, g};
      end
      7: begin
        for (int i = 0; i < 4; i++) px[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        g  = 8'($urandom());
        px = {8'($urandom()), g, g ^ 8'($urandom_range(0, 3)), g};
      end
    endcase
    return px;
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    logic [CFG_W-1:0] w;
    case ($urandom_range(0, 19))
      0:          w = 13'd0;
      1:          w = 13'd4095;
      2:          w = 13'd2048;
      3:          w = 13'd2047;
      4, 5, 6:    w = 13'($urandom_range(13, 40));
      default:    w = 13'($urandom_range(1, 12));
    endcase
    // only twelve bits belong to the width
    w[12] = $urandom_range(0, 1);
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(0, 19))
      0:       return 13'd0;
      1:       return 13'd8191;
      2:       return 13'd4096;
      3:       return 13'd4097;
      4, 5:    return 13'($urandom_range(9, 20));
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_pixel(logic [31:0] px, bit drain);
    pixel_req_t req;
    req.pixel       = px;
    req.drain_first = drain;
    pending_pixels.push_back(req);
  endfunction

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid || halftone_due.size() != 0)
      @(posedge clk);
    // a buffered pixel gives no result, so let the pipeline empty
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] w_data, logic [CFG_W-1:0] h_data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w_data;
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h_data;
    @(negedge clk);
    cfg_write <= 1'b0;
    geom_width  = w_data[11:0];
    geom_height = h_data;
  endtask

  // pixel request driver
  always @(negedge clk) begin : drive_pixels
    pixel_req_t req;
    if (!rst) begin
      if (in_valid && pixels_taken == pixels_sent) gap_left = draw_wait();
      if (!in_valid || pixels_taken == pixels_sent) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0 &&
                     !(pending_pixels[0].drain_first && halftone_due.size() != 0)) begin
          req = pending_pixels.pop_front();
          pixel_word <= req.pixel;
          in_valid   <= 1'b1;
          pixels_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, one draw per result request
  always @(negedge clk) begin : pace_results
    if (!rst) begin
      if (results_taken != stall_mark) begin
        stall_mark = results_taken;
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : take_and_check
    halftone_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        halftone_pixel(pixel_word);
        pixels_taken <= pixels_taken + 1;
      end
      if (out_valid && out_ready) begin
        results_taken <= results_taken + 1;
        if (halftone_due.size() == 0) begin
          $error("unexpected result: row %0d col %0d pixel 0x%06h", out_row, out_col,
                 out_pixel);
          mismatches++;
        end else begin
          want = halftone_due.pop_front();
          check_field("out_row", want.row, out_row);
          check_field("out_col", want.col, out_col);
          check_field("out_pixel", want.pixel, out_pixel);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] new_w, new_h;
    int unsigned n, pad, random_sent;
    foreach (line_gray[i]) line_gray[i] = 8'h00;
    random_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: a wide even row only fills the line buffer
    @(posedge clk);
    queue_pixel(32'h0000_0000, 1'b0);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'hFF00_0000, 1'b0);
    wait_idle();

    // width of zero acts as one, written mid-row
    write_config(13'd0, 13'd480);
    @(posedge clk);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'h00FF_FFFF, 1'b0);
    queue_pixel(32'h1234_5678, 1'b0);
    wait_idle();

    // height of zero: every row is the last, frame wraps at once
    write_config(13'd0, 13'd0);
    @(posedge clk);
    queue_pixel(32'h80FE_01A5, 1'b0);
    queue_pixel(32'h7F00_FF00, 1'b0);
    wait_idle();

    // single cells: sums just under the top cut and just over the bottom one
    write_config(13'd2, 13'd2);
    @(posedge clk);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'h00FF_FFFF, 1'b0);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'h0082_8282, 1'b0);
    queue_pixel(32'h0020_2020, 1'b1);
    queue_pixel(32'hFF20_2020, 1'b0);
    queue_pixel(32'h0020_2020, 1'b0);
    queue_pixel(32'h0021_2121, 1'b0);
    wait_idle();

    // odd width and height: right column and bottom row pass through as gray
    write_config(13'd3, 13'd3);
    @(posedge clk);
    repeat (9) queue_pixel($urandom(), 1'b0);
    wait_idle();

    // oversized registers clamp to the line buffer depth and the height cap
    write_config(13'h1FFF, 13'd8191);
    @(posedge clk);
    queue_pixel($urandom(), 1'b0);
    queue_pixel($urandom(), 1'b0);
    wait_idle();
    write_config(13'd2048, 13'd4096);
    @(posedge clk);
    queue_pixel($urandom(), 1'b0);
    wait_idle();

    while (random_sent < RANDOM_PIXELS) begin
      new_w = pick_width();
      new_h = pick_height();
      // growing the geometry mid-image could read line buffer entries never written
      if (eff_width(new_w[11:0]) > eff_width(geom_width) ||
          eff_height(new_h) > eff_height(geom_height)) begin
        pad = pixels_to_even_row();
        if (pad > PAD_CAP) begin
          new_w = {1'b0, geom_width};
          new_h = geom_height;
        end else if (pad > 0) begin
          @(posedge clk);
          repeat (pad) queue_pixel(make_pixel(), 1'b0);
          random_sent += pad;
          wait_idle();
        end
      end
      steady = ($urandom_range(0, 3) == 0);
      write_config(new_w, new_h);
      n = (eff_width(geom_width) >= 1024) ? $urandom_range(1, 6) : $urandom_range(4, 40);
      @(posedge clk);
      repeat (n) queue_pixel(make_pixel(), $urandom_range(0, 24) == 0);
      random_sent += n;
      wait_idle();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
